// ===== src/rrc_pkg.sv =====
package rrc_pkg;

    // conversion direction, as held in the direction register
    typedef enum logic
    {
        DIR_RGB_TO_RYB = 1'b0,
        DIR_RYB_TO_RGB = 1'b1
    } dir_t;

    // entries in the queue between the front and back pipelines
    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== src/rrc_front.sv =====
module rrc_front
    import rrc_pkg::*;
#(
    parameter int unsigned N = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 hold,
    input  logic                 in_valid,
    input  dir_t                 dir,
    input  logic [N-1:0]         comp_a,
    input  logic [N-1:0]         comp_b,
    input  logic [N-1:0]         comp_c,
    output logic                 out_valid,
    output logic [2*N:0]         prod_a,
    output logic [2*N:0]         prod_b,
    output logic [2*N:0]         prod_c,
    output logic [N:0]           den,
    output logic [N-1:0]         added
);

    // stage a: strip white or black part
    logic         a_vld_reg;
    dir_t         a_dir_reg;
    logic [N-1:0] a_d0_reg, a_d1_reg, a_d2_reg, a_add_reg;
    logic [N-1:0] mx, mn;

    // stage b: recombine, maxima
    logic         b_vld_reg;
    logic [N:0]   b_c0_reg, b_c1_reg, b_c2_reg, b_den_reg;
    logic [N-1:0] b_num_reg, b_add_reg;
    logic [N:0]   c0_next, c1_next, c2_next, den_next;
    logic [N-1:0] num_next, m_sel;

    // stage c: products
    logic         c_vld_reg;
    logic [2*N:0] c_p0_reg, c_p1_reg, c_p2_reg;
    logic [N:0]   c_den_reg;
    logic [N-1:0] c_add_reg;

    always_comb
    begin
        mx = (comp_a > comp_b) ? comp_a : comp_b;
        mx = (mx > comp_c) ? mx : comp_c;
        mn = (comp_a < comp_b) ? comp_a : comp_b;
        mn = (mn < comp_c) ? mn : comp_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (!hold)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            a_dir_reg <= dir;
            a_d0_reg  <= comp_a - mn;
            a_d1_reg  <= comp_b - mn;
            a_d2_reg  <= comp_c - mn;
            a_add_reg <= ~mx;
        end
    end

    always_comb
    begin
        num_next = (a_d0_reg > a_d1_reg) ? a_d0_reg : a_d1_reg;
        num_next = (num_next > a_d2_reg) ? num_next : a_d2_reg;
        case (a_dir_reg)
            DIR_RGB_TO_RYB:
            begin
                m_sel   = (a_d0_reg < a_d1_reg) ? a_d0_reg : a_d1_reg;
                c0_next = {a_d0_reg - m_sel, 1'b0};
                c1_next = {1'b0, a_d1_reg} + {1'b0, m_sel};
                c2_next = {1'b0, a_d2_reg} + {1'b0, a_d1_reg - m_sel};
            end
            DIR_RYB_TO_RGB:
            begin
                m_sel   = (a_d1_reg < a_d2_reg) ? a_d1_reg : a_d2_reg;
                c0_next = {1'b0, a_d0_reg} + {1'b0, a_d1_reg - m_sel};
                c1_next = {1'b0, a_d1_reg} + {1'b0, m_sel};
                c2_next = {a_d2_reg - m_sel, 1'b0};
            end
            default:
            begin
                m_sel   = '0;
                c0_next = '0;
                c1_next = '0;
                c2_next = '0;
            end
        endcase
        den_next = (c0_next > c1_next) ? c0_next : c1_next;
        den_next = (den_next > c2_next) ? den_next : c2_next;
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            b_c0_reg  <= c0_next;
            b_c1_reg  <= c1_next;
            b_c2_reg  <= c2_next;
            b_den_reg <= den_next;
            b_num_reg <= num_next;
            b_add_reg <= a_add_reg;
            c_p0_reg  <= {{N{1'b0}}, b_c0_reg} * {{(N+1){1'b0}}, b_num_reg};
            c_p1_reg  <= {{N{1'b0}}, b_c1_reg} * {{(N+1){1'b0}}, b_num_reg};
            c_p2_reg  <= {{N{1'b0}}, b_c2_reg} * {{(N+1){1'b0}}, b_num_reg};
            c_den_reg <= b_den_reg;
            c_add_reg <= b_add_reg;
        end
    end

    assign out_valid = c_vld_reg && !hold;
    assign prod_a    = c_p0_reg;
    assign prod_b    = c_p1_reg;
    assign prod_c    = c_p2_reg;
    assign den       = c_den_reg;
    assign added     = c_add_reg;

endmodule

// ===== src/rrc_queue.sv =====
module rrc_queue
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/rrc_back.sv =====
module rrc_back
#(
    parameter int unsigned N = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2*N:0]   prod_a,
    input  logic [2*N:0]   prod_b,
    input  logic [2*N:0]   prod_c,
    input  logic [N:0]     den,
    input  logic [N-1:0]   added,
    output logic           out_valid,
    output logic [N-1:0]   res_a,
    output logic [N-1:0]   res_b,
    output logic [N-1:0]   res_c
);

    // one quotient bit per stage, three lanes side by side
    logic         vld_reg [0:N];
    logic [N:0]   den_reg [0:N];
    logic [N-1:0] add_reg [0:N];
    logic [N:0]   rem_reg [0:N][0:2];
    logic [N-1:0] lo_reg  [0:N][0:2];
    logic [N-1:0] quo_reg [0:N][0:2];

    logic         out_vld_reg;
    logic [N-1:0] out_a_reg, out_b_reg, out_c_reg;
    logic [N:0]   sum_next [0:2];
    logic [N-1:0] q_fin [0:2];
    logic [N-1:0] res_next [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // load: top bits of the dividend start the remainder
    always_ff @(posedge clk)
    begin
        den_reg[0]    <= den;
        add_reg[0]    <= added;
        rem_reg[0][0] <= prod_a[2*N:N];
        rem_reg[0][1] <= prod_b[2*N:N];
        rem_reg[0][2] <= prod_c[2*N:N];
        lo_reg[0][0]  <= prod_a[N-1:0];
        lo_reg[0][1]  <= prod_b[N-1:0];
        lo_reg[0][2]  <= prod_c[N-1:0];
        quo_reg[0][0] <= '0;
        quo_reg[0][1] <= '0;
        quo_reg[0][2] <= '0;
    end

    for (genvar s = 1; s <= N; s++)
    begin : g_step
        logic [N+1:0] trial [0:2];
        logic [N+1:0] diff  [0:2];
        logic         take  [0:2];
        logic [N:0]   rem_next [0:2];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l]    = {rem_reg[s-1][l], lo_reg[s-1][l][N-1]};
                diff[l]     = trial[l] - {1'b0, den_reg[s-1]};
                take[l]     = (trial[l] >= {1'b0, den_reg[s-1]});
                rem_next[l] = take[l] ? diff[l][N:0] : trial[l][N:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_reg[s-1];
            add_reg[s] <= add_reg[s-1];
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[s][l] <= rem_next[l];
                lo_reg[s][l]  <= {lo_reg[s-1][l][N-2:0], 1'b0};
                quo_reg[s][l] <= {quo_reg[s-1][l][N-2:0], take[l]};
            end
        end
    end

    // zero maximum: chroma is zero, only the added part remains
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            q_fin[l]    = (den_reg[N] == '0) ? '0 : quo_reg[N][l];
            sum_next[l] = {1'b0, add_reg[N]} + {1'b0, q_fin[l]};
            res_next[l] = sum_next[l][N] ? {N{1'b1}} : sum_next[l][N-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        out_a_reg <= res_next[0];
        out_b_reg <= res_next[1];
        out_c_reg <= res_next[2];
    end

    assign out_valid = out_vld_reg;
    assign res_a     = out_a_reg;
    assign res_b     = out_b_reg;
    assign res_c     = out_c_reg;

endmodule

// ===== src/rgb_ryb_color_converter_top.sv =====
// rgb <-> ryb pixel converter. one pixel beat is taken on each clock where start
// is high and busy is low, so a full pixel stream runs at one beat per cycle.
// each result comes out as a single-cycle result_valid strobe, in input order.
// the path runs through three front stages, the queue, the restoring divider (a
// load stage plus one quotient bit per stage) and the output register. the
// receiver cannot hold results off. busy stays low: the back end takes the queue
// head on every cycle, so the queue between front and back never holds more than
// one entry and never fills. direction is written through cfg_wr_en/cfg_wr_data
// (0: rgb to ryb, 1: ryb to rgb) and must only change while no beat is in flight.
module rgb_ryb_color_converter_top
    import rrc_pkg::*;
#(
    parameter int unsigned COMPONENT_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [COMPONENT_BITS-1:0] component_a,
    input  logic [COMPONENT_BITS-1:0] component_b,
    input  logic [COMPONENT_BITS-1:0] component_c,
    output logic                      result_valid,
    output logic [COMPONENT_BITS-1:0] result_a,
    output logic [COMPONENT_BITS-1:0] result_b,
    output logic [COMPONENT_BITS-1:0] result_c
);

    localparam int unsigned N  = COMPONENT_BITS;
    // queue entry: three products, divisor, added white/black part
    localparam int unsigned QW = 3 * (2 * N + 1) + (N + 1) + N;

    dir_t            direction_reg;

    logic            front_hold;
    logic            front_valid;
    logic [2*N:0]    f_prod_a, f_prod_b, f_prod_c;
    logic [N:0]      f_den;
    logic [N-1:0]    f_added;

    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic [QW-1:0]   q_data;

    // direction register, to be written by the user only between pixels; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_RGB_TO_RYB;
        end
        else if (cfg_wr_en)
        begin
            direction_reg <= dir_t'(cfg_wr_data);
        end
    end

    // back pipeline never stalls, so the head is taken whenever present
    assign q_pop      = q_valid;
    // the whole front freezes only if the queue is full and nothing leaves
    assign front_hold = q_full && !q_pop;
    assign busy       = front_hold;

    // front: strip white/black, recombine by min rules, maxima, products
    rrc_front #(
        .N (N)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (front_hold),
        .in_valid  (start && !busy),
        .dir       (direction_reg),
        .comp_a    (component_a),
        .comp_b    (component_b),
        .comp_c    (component_c),
        .out_valid (front_valid),
        .prod_a    (f_prod_a),
        .prod_b    (f_prod_b),
        .prod_c    (f_prod_c),
        .den       (f_den),
        .added     (f_added)
    );

    // short queue decoupling front and back
    rrc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  ({f_prod_a, f_prod_b, f_prod_c, f_den, f_added}),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data),
        .full       (q_full)
    );

    // back: renormalising divide, add back white/black part, saturate
    rrc_back #(
        .N (N)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .prod_a    (q_data[QW-1 -: 2*N+1]),
        .prod_b    (q_data[QW-1-(2*N+1) -: 2*N+1]),
        .prod_c    (q_data[QW-1-2*(2*N+1) -: 2*N+1]),
        .den       (q_data[2*N:N]),
        .added     (q_data[N-1:0]),
        .out_valid (result_valid),
        .res_a     (result_a),
        .res_b     (result_b),
        .res_c     (result_c)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import rrc_pkg::*;
();

    localparam int unsigned COMP_BITS     = 8;
    localparam int unsigned FULL          = (1 << COMP_BITS) - 1;
    localparam int unsigned PERIOD        = 12;
    // divider stages plus front, queue and output register
    localparam int unsigned LATENCY       = COMP_BITS + 6;
    localparam int unsigned RANDOM_PIXELS = 1626;
    localparam int unsigned RANDOM_PHASES = 6;

    typedef logic [COMP_BITS-1:0] comp_t;
    typedef struct packed
    {
        comp_t a;
        comp_t b;
        comp_t c;
    } pixel_t;

    // expected converted pixels, in beat order, and the checks against them
    class ryb_scoreboard;
        dir_t        direction = DIR_RGB_TO_RYB;
        pixel_t      pending_q[$];
        int unsigned checked   = 0;
        int unsigned errors    = 0;

        static function int unsigned min3(int unsigned x, int unsigned y, int unsigned z);
            int unsigned m;
            m = (x < y) ? x : y;
            return (m < z) ? m : z;
        endfunction

        static function int unsigned max3(int unsigned x, int unsigned y, int unsigned z);
            int unsigned m;
            m = (x > y) ? x : y;
            return (m > z) ? m : z;
        endfunction

        // chroma times the ratio of maxima plus the black or white part, saturated
        static function comp_t rescale(int unsigned chroma, int unsigned num,
                                       int unsigned den, int unsigned half,
                                       int unsigned added);
            int unsigned v;
            if (num == 0 || den == 0)
                v = (chroma + added * half) / half;
            else
                v = (chroma * num + added * den) / den;
            return comp_t'((v > FULL) ? FULL : v);
        endfunction

        function pixel_t convert_pixel(pixel_t p);
            int unsigned x, y, z, base, m, num, den, half, added;
            int unsigned ch [3];
            pixel_t      q;
            base  = min3(p.a, p.b, p.c);
            x     = p.a - base;
            y     = p.b - base;
            z     = p.c - base;
            added = FULL - max3(p.a, p.b, p.c);
            if (direction == DIR_RGB_TO_RYB)
            begin
                // ryb parts kept in doubled units
                m     = (x < y) ? x : y;
                ch[0] = 2 * (x - m);
                ch[1] = y + m;
                ch[2] = z + y - m;
                num   = max3(x, y, z);
                den   = max3(ch[0], ch[1], ch[2]);
                half  = 2;
            end
            else
            begin
                m     = (y < z) ? y : z;
                ch[0] = x + y - m;
                ch[1] = y + m;
                ch[2] = 2 * (z - m);
                num   = max3(x, y, z);
                den   = max3(ch[0], ch[1], ch[2]);
                half  = 1;
            end
            q.a = rescale(ch[0], num, den, half, added);
            q.b = rescale(ch[1], num, den, half, added);
            q.c = rescale(ch[2], num, den, half, added);
            return q;
        endfunction

        function void note_pixel(pixel_t p);
            pending_q = {pending_q, convert_pixel(p)};
        endfunction

        function void check_result(pixel_t got);
            pixel_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result %0d/%0d/%0d", got.a, got.b, got.c);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.a !== want.a)
            begin
                $error("result_a: expected %0d, got %0d", want.a, got.a);
                errors++;
            end
            if (got.b !== want.b)
            begin
                $error("result_b: expected %0d, got %0d", want.b, got.b);
                errors++;
            end
            if (got.c !== want.c)
            begin
                $error("result_c: expected %0d, got %0d", want.c, got.c);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    // block ports, the inputs all driven to known values from time zero
    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  cfg_wr_en    = 1'b0;
    logic  cfg_wr_data  = 1'b0;
    logic  start        = 1'b0;
    logic  busy;
    comp_t component_a  = '0;
    comp_t component_b  = '0;
    comp_t component_c  = '0;
    logic  result_valid;
    comp_t result_a;
    comp_t result_b;
    comp_t result_c;

    ryb_scoreboard sb;
    int unsigned   n_rgb_to_ryb = 0;
    int unsigned   n_ryb_to_rgb = 0;
    int unsigned   n_dir_writes = 0;
    pixel_t        corners [12];

    rgb_ryb_color_converter_top #(
        .COMPONENT_BITS(COMP_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .component_a (component_a),
        .component_b (component_b),
        .component_c (component_c),
        .result_valid(result_valid),
        .result_a    (result_a),
        .result_b    (result_b),
        .result_c    (result_c)
    );

    initial
    begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    // result side: the strobe cannot be held off, so every edge with
    // result_valid high is a beat; values read here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result({result_a, result_b, result_c});
    end

    // one pixel beat: hold start and the components until an edge with busy low
    task automatic send_pixel(pixel_t p);
        start       <= 1'b1;
        component_a <= p.a;
        component_b <= p.b;
        component_c <= p.c;
        do
            @(posedge clk);
        while (busy);
        sb.note_pixel(p);
        if (sb.direction == DIR_RGB_TO_RYB)
            n_rgb_to_ryb++;
        else
            n_ryb_to_rgb++;
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending and wait for every pending result, with a bound
    task automatic drain();
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        while (sb.outstanding() != 0 && waited < 4 * LATENCY + 100)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.outstanding() != 0)
        begin
            $error("%0d results never arrived", sb.outstanding());
            sb.errors++;
            sb.pending_q.delete();
        end
    endtask

    // direction changes only with the pipeline empty
    task automatic write_direction(dir_t d);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        sb.direction = d;
        cfg_wr_en   <= 1'b0;
        n_dir_writes++;
    endtask

    // mix of plain random pixels and the shapes where the min rules get busy
    function automatic pixel_t random_pixel();
        int unsigned kind;
        comp_t       v;
        pixel_t      p;
        kind = $urandom_range(99, 0);
        p.a  = comp_t'($urandom);
        p.b  = comp_t'($urandom);
        p.c  = comp_t'($urandom);
        v    = comp_t'($urandom);
        if (kind < 45)
        begin
            // fully random components
        end
        else if (kind < 55)
        begin
            // grey: both maxima zero, ratio taken as one
            p = {v, v, v};
        end
        else if (kind < 67)
        begin
            // two components equal, ties in min and max
            case ($urandom_range(2, 0))
                0: p.b = p.a;
                1: p.c = p.b;
                default: p.c = p.a;
            endcase
        end
        else if (kind < 77)
        begin
            // every component at an end of its range
            p.a = $urandom_range(1, 0) ? comp_t'(FULL) : '0;
            p.b = $urandom_range(1, 0) ? comp_t'(FULL) : '0;
            p.c = $urandom_range(1, 0) ? comp_t'(FULL) : '0;
        end
        else if (kind < 87)
        begin
            // near the ends, where truncation and saturation bite
            p.a = $urandom_range(1, 0) ? comp_t'($urandom_range(3, 0))
                                       : comp_t'(FULL - $urandom_range(3, 0));
            p.b = $urandom_range(1, 0) ? comp_t'($urandom_range(3, 0))
                                       : comp_t'(FULL - $urandom_range(3, 0));
            p.c = $urandom_range(1, 0) ? comp_t'($urandom_range(3, 0))
                                       : comp_t'(FULL - $urandom_range(3, 0));
        end
        else
        begin
            // one strong component over small ones
            p.a = comp_t'($urandom_range(16, 0));
            p.b = comp_t'($urandom_range(16, 0));
            p.c = comp_t'($urandom_range(16, 0));
            case ($urandom_range(2, 0))
                0: p.a = comp_t'($urandom_range(FULL, FULL / 2));
                1: p.b = comp_t'($urandom_range(FULL, FULL / 2));
                default: p.c = comp_t'($urandom_range(FULL, FULL / 2));
            endcase
        end
        return p;
    endfunction

    initial
    begin
        int unsigned per_phase;
        int unsigned burst;
        int unsigned gap;

        sb        = new;
        per_phase = RANDOM_PIXELS / RANDOM_PHASES;

        // primaries, secondaries, black, white, grey, one-step neighbors and one mixed color
        corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                    24'h808080, 24'h010000, 24'hFEFFFF, 24'hC86432};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels in both directions, back to back
        write_direction(DIR_RGB_TO_RYB);
        foreach (corners[i])
            send_pixel(corners[i]);
        write_direction(DIR_RYB_TO_RGB);
        foreach (corners[i])
            send_pixel(corners[i]);

        // random phases, alternating direction, each starting from an empty pipe
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_direction(dir_t'(ph % 2));
            burst = $urandom_range(40, 1);
            for (int unsigned i = 0; i < per_phase; i++)
            begin
                send_pixel(random_pixel());
                // full stop mid-phase on odd phases: let the pipe run dry
                if (ph % 2 == 1 && i == per_phase / 2)
                    drain();
                burst--;
                if (burst == 0)
                begin
                    // long unbroken runs now and then, otherwise short bursts
                    burst = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60)
                                                        : $urandom_range(40, 1);
                    gap   = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 15)
                                                        : $urandom_range(6, 1);
                    hold_off(gap);
                end
            end
        end

        // let the pipe empty, then watch a while for stray strobes
        drain();
        repeat (LATENCY + 4) @(posedge clk);

        $display("tb_top: %0d pixels checked, %0d rgb->ryb and %0d ryb->rgb",
                 sb.checked, n_rgb_to_ryb, n_ryb_to_rgb);
        $display("tb_top: %0d direction writes, %0d mismatches", n_dir_writes, sb.errors);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
